### rtl/evhc_pkg.sv
// Shared types and constants for the edge vertex hash cache.
package evhc_pkg;

	localparam int GRID_SIDE_DEF    = 8;
	localparam int BUCKET_SLOTS_DEF = 8;
	localparam int VERTEX_BITS_DEF  = 16;

	localparam int COORD_W  = 3;
	localparam int VIN_W    = 16;
	localparam int ACTION_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_RSVD   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ADDR,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} corner_t;

	typedef struct packed {
		corner_t lo;
		corner_t hi;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	typedef struct packed {
		logic hit;
		logic full;
	} match_flags_t;

endpackage

### rtl/evhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module evhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/evhc_key.sv
// Edge key builder: corner ordering and bucket hash.
module evhc_key #(
	parameter int GRID_SIDE = evhc_pkg::GRID_SIDE_DEF,
	localparam int BKT_W = $clog2(2 * GRID_SIDE * GRID_SIDE * GRID_SIDE)
) (
	input  evhc_pkg::corner_t first,
	input  evhc_pkg::corner_t second,
	output evhc_pkg::key_t    key,
	output logic [BKT_W-1:0]  bucket
);
	import evhc_pkg::*;

	localparam int CMAX     = (1 << COORD_W) - 1;
	localparam int CID_MAX  = (CMAX * GRID_SIDE + CMAX) * GRID_SIDE + CMAX;
	localparam int SUM_MAX  = 2 * CID_MAX;
	localparam int SUM_W    = $clog2(SUM_MAX + 1);
	localparam int BKT_CNT  = 2 * GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int MAX_Q    = SUM_MAX / BKT_CNT;

	logic             swap;
	logic [SUM_W-1:0] id_lo;
	logic [SUM_W-1:0] id_hi;
	logic [SUM_W-1:0] rem;

	// packed compare of {x,y,z} is the lexicographic order
	assign swap   = first > second;
	assign key.lo = swap ? second : first;
	assign key.hi = swap ? first : second;

	assign id_lo = (SUM_W'(key.lo.x) * SUM_W'(GRID_SIDE) + SUM_W'(key.lo.y))
		* SUM_W'(GRID_SIDE) + SUM_W'(key.lo.z);
	assign id_hi = (SUM_W'(key.hi.x) * SUM_W'(GRID_SIDE) + SUM_W'(key.hi.y))
		* SUM_W'(GRID_SIDE) + SUM_W'(key.hi.z);

	// wrap only matters for small grids; MAX_Q compare-subtract steps
	always_comb begin
		rem = id_lo + id_hi;
		for (int i = 0; i < MAX_Q; i++) begin
			if (rem >= SUM_W'(BKT_CNT)) begin
				rem = rem - SUM_W'(BKT_CNT);
			end
		end
	end

	assign bucket = BKT_W'(rem);

endmodule

### rtl/evhc_match.sv
// Bucket word compare for lookups and slot merge for inserts.
module evhc_match #(
	parameter int BUCKET_SLOTS = evhc_pkg::BUCKET_SLOTS_DEF,
	parameter int VERTEX_BITS  = evhc_pkg::VERTEX_BITS_DEF,
	localparam int FW     = $clog2(BUCKET_SLOTS + 1),
	localparam int SLOT_W = evhc_pkg::KEY_W + VERTEX_BITS,
	localparam int WORD_W = BUCKET_SLOTS * SLOT_W
) (
	input  logic [WORD_W-1:0]       word,
	input  logic [FW-1:0]           fill,
	input  evhc_pkg::key_t          key,
	input  logic [VERTEX_BITS-1:0]  vin,
	output evhc_pkg::match_flags_t  flags,
	output logic [VERTEX_BITS-1:0]  hit_vid,
	output logic [WORD_W-1:0]       new_word
);
	import evhc_pkg::*;

	logic [SLOT_W-1:0] new_slot;

	assign new_slot   = {key, vin};

	// descending scan so the earliest matching slot wins
	always_comb begin
		logic [SLOT_W-1:0] slot;
		flags.full = fill >= FW'(BUCKET_SLOTS);
		flags.hit  = 1'b0;
		hit_vid    = '0;
		slot       = '0;
		for (int k = BUCKET_SLOTS - 1; k >= 0; k--) begin
			slot = word[k*SLOT_W +: SLOT_W];
			if ((FW'(k) < fill) && (slot[SLOT_W-1 -: KEY_W] == key)) begin
				flags.hit = 1'b1;
				hit_vid   = slot[VERTEX_BITS-1:0];
			end
		end
	end

	always_comb begin
		new_word = word;
		for (int k = 0; k < BUCKET_SLOTS; k++) begin
			if (FW'(k) == fill) begin
				new_word[k*SLOT_W +: SLOT_W] = new_slot;
			end
		end
	end

endmodule

### rtl/edge_vertex_hash_cache_top.sv
// Top level of the edge vertex hash cache: control, bucket memories, result register.
//
// Input channel (in_valid / in_stall): one beat carries an action and the two
// corners of a grid edge, plus a vertex id for inserts. Output channel
// (out_valid / out_stall): one result beat per input beat, in order, with
// found, vertex_out and overflow.
// The corners are ordered, hashed to a bucket and registered at accept. The
// next cycle reads the bucket's fill count and its wide slot word from two
// single-port-read RAMs; the cycle after that compares all slots at once,
// writes back an insert and loads the result register.
// Path: accept registers, the ADDR read, then the EVAL step, which loads
// the result register. A new beat can already be taken in the evaluate
// cycle, as the last one retires, so the insert write-back lands before
// the next read of the bucket memory.
// Clear: the result beat is issued right away, then the fill memory is
// swept to zero, one bucket per cycle over all 2*GRID_SIDE^3 buckets (1024
// at the default), with in_stall held high. The same sweep runs after arst_n.
// Receiver stall: the result register holds its beat; the block finishes
// the evaluate step only once the register is free, and stalls its input.
module edge_vertex_hash_cache_top #(
	parameter int GRID_SIDE    = evhc_pkg::GRID_SIDE_DEF,
	parameter int BUCKET_SLOTS = evhc_pkg::BUCKET_SLOTS_DEF,
	parameter int VERTEX_BITS  = evhc_pkg::VERTEX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [evhc_pkg::ACTION_W-1:0]  action,
	input  logic [evhc_pkg::COORD_W-1:0]   first_x,
	input  logic [evhc_pkg::COORD_W-1:0]   first_y,
	input  logic [evhc_pkg::COORD_W-1:0]   first_z,
	input  logic [evhc_pkg::COORD_W-1:0]   second_x,
	input  logic [evhc_pkg::COORD_W-1:0]   second_y,
	input  logic [evhc_pkg::COORD_W-1:0]   second_z,
	input  logic [evhc_pkg::VIN_W-1:0]     vertex_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [evhc_pkg::VIN_W-1:0]     vertex_out,
	output logic                           overflow
);
	import evhc_pkg::*;

	localparam int BKT_CNT = 2 * GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int BKT_W   = $clog2(BKT_CNT);
	localparam int FW      = $clog2(BUCKET_SLOTS + 1);
	localparam int SLOT_W  = KEY_W + VERTEX_BITS;
	localparam int WORD_W  = BUCKET_SLOTS * SLOT_W;

	// FSM
	state_t state_q, state_nxt;

	// accepted beat
	action_t                act_s1;
	key_t                   key_s1;
	logic [BKT_W-1:0]       bkt_s1;
	logic [VERTEX_BITS-1:0] vin_s1;

	// key builder
	corner_t          first_c;
	corner_t          second_c;
	key_t             key_in;
	logic [BKT_W-1:0] bkt_in;
	logic [VERTEX_BITS-1:0] vin_in;

	// memories
	logic [FW-1:0]     fill_rd;
	logic [WORD_W-1:0] word_rd;
	logic              rd_en;
	logic              fill_we;
	logic [BKT_W-1:0]  fill_wa;
	logic [FW-1:0]     fill_wd;
	logic              ent_we;

	// match
	match_flags_t           flags;
	logic [VERTEX_BITS-1:0] hit_vid;
	logic [WORD_W-1:0]      new_word;
	logic [VIN_W-1:0]       hit_vid16;

	// sweep and handshake
	logic [BKT_W-1:0] sweep_q;
	logic             out_free;
	logic             accept;
	logic             eval_done;
	logic             out_valid_q;

	assign first_c  = '{x: first_x, y: first_y, z: first_z};
	assign second_c = '{x: second_x, y: second_y, z: second_z};

	evhc_key #(
		.GRID_SIDE (GRID_SIDE)
	) u_key (
		.first  (first_c),
		.second (second_c),
		.key    (key_in),
		.bucket (bkt_in)
	);

	// vertex id width adaption in and out
	if (VERTEX_BITS > VIN_W) begin : g_vin_wide
		assign vin_in    = {{(VERTEX_BITS - VIN_W){1'b0}}, vertex_in};
		assign hit_vid16 = hit_vid[VIN_W-1:0];
	end else if (VERTEX_BITS == VIN_W) begin : g_vin_same
		assign vin_in    = vertex_in;
		assign hit_vid16 = hit_vid;
	end else begin : g_vin_narrow
		assign vin_in    = vertex_in[VERTEX_BITS-1:0];
		assign hit_vid16 = {{(VIN_W - VERTEX_BITS){1'b0}}, hit_vid};
	end

	// handshake terms
	assign out_free  = !out_valid_q || !out_stall;
	assign eval_done = (state_q == ST_EVAL) && out_free;
	assign accept    = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == BKT_W'(BKT_CNT - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				if (out_free) begin
					if (act_s1 == ACT_CLEAR) begin
						state_nxt = ST_SWEEP;
					end else if (accept) begin
						state_nxt = ST_ADDR;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_SWEEP;
			end
		endcase
	end

	// outputs of the FSM
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		fill_we  = 1'b0;
		fill_wa  = bkt_s1;
		fill_wd  = fill_rd + FW'(1);
		ent_we   = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				fill_we = 1'b1;
				fill_wa = sweep_q;
				fill_wd = '0;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_ADDR: begin
				rd_en = 1'b1;
			end
			ST_EVAL: begin
				// next beat may enter as this one retires, unless a sweep follows
				in_stall = !(out_free && (act_s1 != ACT_CLEAR));
				if (out_free && (act_s1 == ACT_INSERT) && !flags.full) begin
					fill_we = 1'b1;
					ent_we  = 1'b1;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (eval_done && (act_s1 == ACT_CLEAR)) begin
				sweep_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + BKT_W'(1);
			end
			if (eval_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// beat payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action_t'(action);
			key_s1 <= key_in;
			bkt_s1 <= bkt_in;
			vin_s1 <= vin_in;
		end
		if (eval_done) begin
			found      <= (act_s1 == ACT_LOOKUP) && flags.hit;
			vertex_out <= ((act_s1 == ACT_LOOKUP) && flags.hit) ? hit_vid16 : '0;
			overflow   <= (act_s1 == ACT_INSERT) && flags.full;
		end
	end

	assign out_valid = out_valid_q;

	// per-bucket fill counts (cleared by sweep)
	evhc_ram #(
		.WIDTH (FW),
		.DEPTH (BKT_CNT)
	) u_fill_ram (
		.clk     (clk),
		.wr_en   (fill_we),
		.wr_addr (fill_wa),
		.wr_data (fill_wd),
		.rd_en   (rd_en),
		.rd_addr (bkt_s1),
		.rd_data (fill_rd)
	);

	// per-bucket slot words (never cleared; only slots below fill are matched)
	evhc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BKT_CNT)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (bkt_s1),
		.wr_data (new_word),
		.rd_en   (rd_en),
		.rd_addr (bkt_s1),
		.rd_data (word_rd)
	);

	evhc_match #(
		.BUCKET_SLOTS (BUCKET_SLOTS),
		.VERTEX_BITS  (VERTEX_BITS)
	) u_match (
		.word     (word_rd),
		.fill     (fill_rd),
		.key      (key_s1),
		.vin      (vin_s1),
		.flags    (flags),
		.hit_vid  (hit_vid),
		.new_word (new_word)
	);

	// no beat enters while the fill memory is being swept
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> in_stall)
		else $error("beat accepted during fill sweep");

	// slot writes come only from an insert into a bucket with room
	a_ent_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> ((state_q == ST_EVAL) && (act_s1 == ACT_INSERT) && !flags.full))
		else $error("slot write outside insert evaluate");

	// a new result beat appears only right after an evaluate cycle
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EVAL))
		else $error("result beat without evaluate");

	// a result never reports both a hit and an overflow
	a_hit_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found && overflow))
		else $error("found and overflow both set");

endmodule
